// File: rtl/sstq_pkg.sv
// Shared types, constants and codes for the sorted sleep timer queue.
package sstq_pkg;

	localparam int MAX_TASKS_DEF = 64;
	localparam int TASK_W = 6;
	localparam int NUM_IDS = 2 ** TASK_W;
	localparam int TICK_W = 32;
	localparam int PERIOD_W = 16;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;
	localparam int DIV_STEPS = TICK_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int ENTRY_W = TASK_W + TICK_W;

	typedef enum logic [1:0] {
		ST_QUEUED   = 2'd0,
		ST_REJECTED = 2'd1,
		ST_WOKEN    = 2'd2,
		ST_NONE     = 2'd3
	} status_t;

	typedef struct packed {
		logic              mode;
		logic [TASK_W-1:0] task_id;
		logic [TICK_W-1:0] sleep_ms;
		logic [TICK_W-1:0] now_tick;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [TASK_W-1:0] out_task;
		logic [TICK_W-1:0] wake_tick;
		logic              last;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_WAKE,
		S_CHECK,
		S_INS_RD,
		S_INS_CMP,
		S_INS_NEW,
		S_EMIT_Q,
		S_EMIT_R,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SCAN_END
	} sstq_state_t;

	// Source and position of a queue write during an insert.
	typedef enum logic [1:0] {
		WR_SHIFT,
		WR_NEW_UP,
		WR_NEW_AT
	} wr_sel_t;

	typedef struct packed {
		logic    load_in;
		logic    div_step;
		logic    wake_calc;
		logic    idx_init;
		logic    idx_dec;
		logic    rd_use_idx;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    commit_ins;
		logic    scan_pop;
		logic    out_load;
		status_t out_status;
		logic    out_last;
	} sstq_cmd_t;

	typedef struct packed {
		logic in_mode;
		logic div_last;
		logic hit;
		logic cnt_zero;
		logic idx_zero;
		logic rd_gt_wake;
		logic rd_le_now;
		logic pend_valid;
		logic out_free;
	} sstq_sts_t;

endpackage

// File: rtl/sstq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sstq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/sstq_ctrl.sv
// Controller state machine for the sorted sleep timer queue.
module sstq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sstq_pkg::sstq_sts_t sts,
	output sstq_pkg::sstq_cmd_t cmd
);
	import sstq_pkg::*;

	sstq_state_t state_q;
	sstq_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = sts.in_mode ? S_SCAN_RD : S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_last) begin
					state_nxt = S_WAKE;
				end
			end
			S_WAKE: state_nxt = S_CHECK;
			S_CHECK: begin
				if (sts.hit) begin
					state_nxt = S_EMIT_R;
				end else if (sts.cnt_zero) begin
					state_nxt = S_INS_NEW;
				end else begin
					state_nxt = S_INS_RD;
				end
			end
			S_INS_RD: state_nxt = S_INS_CMP;
			S_INS_CMP: begin
				if (sts.rd_gt_wake) begin
					state_nxt = sts.idx_zero ? S_INS_NEW : S_INS_RD;
				end else begin
					state_nxt = S_EMIT_Q;
				end
			end
			S_INS_NEW: state_nxt = S_EMIT_Q;
			S_EMIT_Q, S_EMIT_R: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_SCAN_RD: state_nxt = sts.cnt_zero ? S_SCAN_END : S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (!sts.rd_le_now) begin
					state_nxt = S_SCAN_END;
				end else if (!sts.pend_valid || sts.out_free) begin
					state_nxt = S_SCAN_RD;
				end
			end
			S_SCAN_END: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
			end
			S_DIV: cmd.div_step = 1'b1;
			S_WAKE: cmd.wake_calc = 1'b1;
			S_CHECK: cmd.idx_init = 1'b1;
			S_INS_RD: cmd.rd_use_idx = 1'b1;
			S_INS_CMP: begin
				cmd.rd_use_idx = 1'b1;
				cmd.wr_en = 1'b1;
				if (sts.rd_gt_wake) begin
					cmd.wr_sel = WR_SHIFT;
					cmd.idx_dec = !sts.idx_zero;
				end else begin
					cmd.wr_sel = WR_NEW_UP;
					cmd.commit_ins = 1'b1;
				end
			end
			S_INS_NEW: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WR_NEW_AT;
				cmd.commit_ins = 1'b1;
			end
			S_EMIT_Q: begin
				cmd.out_load = sts.out_free;
				cmd.out_status = ST_QUEUED;
				cmd.out_last = 1'b1;
			end
			S_EMIT_R: begin
				cmd.out_load = sts.out_free;
				cmd.out_status = ST_REJECTED;
				cmd.out_last = 1'b1;
			end
			S_SCAN_RD: begin
			end
			S_SCAN_CHK: begin
				// An expired entry is popped into the pending slot once the entry
				// already held there has been handed to the output register.
				if (sts.rd_le_now && (!sts.pend_valid || sts.out_free)) begin
					cmd.scan_pop = 1'b1;
					cmd.out_load = sts.pend_valid;
					cmd.out_status = ST_WOKEN;
					cmd.out_last = 1'b0;
				end
			end
			S_SCAN_END: begin
				cmd.out_load = sts.out_free;
				cmd.out_status = sts.pend_valid ? ST_WOKEN : ST_NONE;
				cmd.out_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/sstq_dp.sv
// Datapath: divider, queue memory with head pointer, task mask and output register.
module sstq_dp #(
	parameter int MAX_TASKS = sstq_pkg::MAX_TASKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sstq_pkg::in_item_t  in_data,
	input  logic                cfg_valid,
	input  logic [sstq_pkg::PERIOD_W-1:0] cfg_data,
	input  sstq_pkg::sstq_cmd_t cmd,
	output sstq_pkg::sstq_sts_t sts,
	output logic                out_valid,
	input  logic                out_ready,
	output sstq_pkg::out_item_t out_data
);
	import sstq_pkg::*;

	localparam int ADDR_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	logic [PERIOD_W-1:0]  period_q;
	logic [PERIOD_W-1:0]  divisor_q;
	logic [PERIOD_W-1:0]  rem_q;
	logic [TICK_W-1:0]    dq_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [TASK_W-1:0]    task_q;
	logic [TICK_W-1:0]    now_q;
	logic [TICK_W-1:0]    wake_q;
	logic [ADDR_W-1:0]    head_q;
	logic [CNT_W-1:0]     count_q;
	logic [ADDR_W-1:0]    idx_q;
	logic [NUM_IDS-1:0]   mask_q;
	logic                 pend_valid_q;
	logic [TASK_W-1:0]    pend_task_q;
	logic [TICK_W-1:0]    pend_wake_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [PERIOD_W:0]    trial;
	logic [PERIOD_W+1:0]  diff;
	logic                 ge;
	logic [TICK_W-1:0]    ticks;
	logic                 out_free;
	logic [ADDR_W-1:0]    raddr;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    wpos;
	logic [ENTRY_W-1:0]   wdata;
	logic [ENTRY_W-1:0]   rdata;
	logic [TASK_W-1:0]    rd_task;
	logic [TICK_W-1:0]    rd_wake;

	// Map a position in the queue to a memory address; the queue is circular.
	function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
			input logic [ADDR_W-1:0] off);
		logic [ADDR_W:0] sum;
		sum = {1'b0, head} + {1'b0, off};
		if (sum >= (ADDR_W+1)'(MAX_TASKS)) begin
			sum = sum - (ADDR_W+1)'(MAX_TASKS);
		end
		return sum[ADDR_W-1:0];
	endfunction

	assign rd_task = rdata[ENTRY_W-1:TICK_W];
	assign rd_wake = rdata[TICK_W-1:0];

	// One restoring division step per cycle.
	assign trial = {rem_q, dq_q[TICK_W-1]};
	assign diff = {1'b0, trial} - {2'b00, divisor_q};
	assign ge = ~diff[PERIOD_W+1];
	assign ticks = (dq_q == '0) ? TICK_W'(1) : dq_q;

	assign out_free = !out_valid_q || out_ready;

	assign raddr = phys(head_q, cmd.rd_use_idx ? idx_q : '0);
	assign wpos = (cmd.wr_sel == WR_NEW_AT) ? idx_q : idx_q + ADDR_W'(1);
	assign waddr = phys(head_q, wpos);

	always_comb begin
		unique case (cmd.wr_sel)
			WR_SHIFT: wdata = rdata;
			WR_NEW_UP, WR_NEW_AT: wdata = {task_q, wake_q};
			default: wdata = {task_q, wake_q};
		endcase
	end

	sstq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_TASKS)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			div_cnt_q <= '0;
			head_q <= '0;
			count_q <= '0;
			mask_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				period_q <= cfg_data;
			end
			if (cmd.load_in) begin
				div_cnt_q <= '0;
				pend_valid_q <= 1'b0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.commit_ins) begin
				count_q <= count_q + CNT_W'(1);
				mask_q[task_q] <= 1'b1;
			end
			if (cmd.scan_pop) begin
				head_q <= (head_q == ADDR_W'(MAX_TASKS - 1)) ? '0 : head_q + ADDR_W'(1);
				count_q <= count_q - CNT_W'(1);
				mask_q[rd_task] <= 1'b0;
				pend_valid_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			task_q <= in_data.task_id;
			now_q <= in_data.now_tick;
			dq_q <= in_data.sleep_ms;
			rem_q <= '0;
			divisor_q <= (period_q == '0) ? PERIOD_W'(1) : period_q;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
			dq_q <= {dq_q[TICK_W-2:0], ge};
		end
		if (cmd.wake_calc) begin
			wake_q <= now_q + ticks;
		end
		if (cmd.idx_init) begin
			idx_q <= (count_q == '0) ? '0 : ADDR_W'(count_q - CNT_W'(1));
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - ADDR_W'(1);
		end
		if (cmd.scan_pop) begin
			pend_task_q <= rd_task;
			pend_wake_q <= rd_wake;
		end
		if (cmd.out_load) begin
			out_q.status <= cmd.out_status;
			out_q.last <= cmd.out_last;
			unique case (cmd.out_status)
				ST_QUEUED, ST_REJECTED: begin
					out_q.out_task <= task_q;
					out_q.wake_tick <= wake_q;
				end
				ST_WOKEN: begin
					out_q.out_task <= pend_task_q;
					out_q.wake_tick <= pend_wake_q;
				end
				ST_NONE: begin
					out_q.out_task <= '0;
					out_q.wake_tick <= '0;
				end
				default: begin
					out_q.out_task <= '0;
					out_q.wake_tick <= '0;
				end
			endcase
		end
	end

	always_comb begin
		sts.in_mode = in_data.mode;
		sts.div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
		sts.hit = mask_q[task_q] || (count_q >= CNT_W'(MAX_TASKS));
		sts.cnt_zero = (count_q == '0);
		sts.idx_zero = (idx_q == '0);
		sts.rd_gt_wake = (rd_wake > wake_q);
		sts.rd_le_now = (rd_wake <= now_q);
		sts.pend_valid = pend_valid_q;
		sts.out_free = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// File: rtl/sorted_sleep_timer_queue.sv
// Top level of the sorted sleep timer queue: controller, datapath and checks.
//
// Usage: items arrive on in_valid/in_ready/in_data. A sleep request (mode 0)
// divides sleep_ms by the tick period, adds it to now_tick and inserts the task
// in wake order, or rejects it when it is already queued or the queue is full; it
// yields one result. A wake scan (mode 1) removes every leading entry whose wake
// tick is not later than now_tick and yields one result per woken task, with last
// set on the final one, or a single "nothing expired" result. Results leave on
// out_valid/out_ready/out_data. The tick period must be written through
// cfg_valid/cfg_ready/cfg_data only while idle; the block itself does not enforce
// this. One item is handled at a time. A sleep request runs the 32-step bit-serial
// divider, forms the wake tick and checks the task mask and the fill level; a
// rejection then emits its result, otherwise the queue is walked from the tail,
// shifting each entry that sorts after the new one up one place, and the task is
// written into the gap. A wake scan reads the head entry and pops it for as long
// as it has expired. A result sits in the output register; when the receiver
// stalls, a scan holds until each transfer is taken and the next item is accepted
// only once the current one is finished.
// Reset empties the queue and sets the tick period to 10 ms; no clearing pass.
module sorted_sleep_timer_queue #(
	parameter int MAX_TASKS = sstq_pkg::MAX_TASKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sstq_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sstq_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [sstq_pkg::PERIOD_W-1:0] cfg_data
);
	import sstq_pkg::*;

	sstq_cmd_t cmd;
	sstq_sts_t sts;

	assign cfg_ready = 1'b1;

	sstq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	sstq_dp #(
		.MAX_TASKS(MAX_TASKS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in work");

	// Only a woken task can be followed by more results of the same scan.
	a_not_last_woken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.status == ST_WOKEN)
		else $error("non-final result that is not a wake report");

	// An empty scan reports zero fields.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_NONE
		|-> out_data.out_task == '0 && out_data.wake_tick == '0 && out_data.last)
		else $error("empty scan result carries data");

	// Inserts and scan pops never touch the queue in the same cycle.
	a_wr_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.scan_pop))
		else $error("queue write and pop in one cycle");
`endif

endmodule
